// ===== design/cbe_pkg.sv =====
// shared types and constants for the crc codeword byte encoder
`default_nettype none
package cbe_pkg;

	// largest generator length, leading one included
	localparam int MAX_GEN_BITS = 16;
	// remainder word, left aligned to the top bit
	localparam int REM_W = MAX_GEN_BITS;
	localparam int BYTE_W = 8;
	localparam int NIB_W = 4;
	localparam int LEN_W = 5;
	// one codeword of up to three bytes
	localparam int CW_BYTES = 3;
	localparam int CW_W = CW_BYTES * BYTE_W;
	// two codewords per item at most
	localparam int MAX_BYTES = 2 * CW_BYTES;
	localparam int STREAM_W = MAX_BYTES * BYTE_W;
	localparam int CNT_W = 3;
	localparam int NB_W = 2;

	// configuration register indexes
	localparam logic [1:0] REG_GEN_LEN = 2'd0;
	localparam logic [1:0] REG_GEN_BITS = 2'd1;
	localparam logic [1:0] REG_NIBBLE_MODE = 2'd2;

	// configuration as seen by the encoder core
	typedef struct packed {
		logic [LEN_W-1:0] gen_len;
		logic [REM_W-1:0] gen_bits;
		logic nibble_mode;
	} cfg_t;

	// bytes of one item, first byte in the top bits
	typedef struct packed {
		logic [STREAM_W-1:0] bytes;
		logic [CNT_W-1:0] count;
	} frame_t;

endpackage
`default_nettype wire

// ===== design/cbe_core.sv =====
// crc remainder and codeword byte packing for one input item
`default_nettype none
module cbe_core (
	input  wire cbe_pkg::cfg_t            cfg,
	input  wire logic [cbe_pkg::BYTE_W-1:0] data_byte,
	output cbe_pkg::frame_t               frame
);

	logic [cbe_pkg::LEN_W-1:0] eff_len;
	logic [3:0] g;
	logic [cbe_pkg::REM_W-1:0] mask;
	logic [cbe_pkg::REM_W-1:0] poly_l;
	logic [cbe_pkg::REM_W-1:0] rem8;
	logic [cbe_pkg::REM_W-1:0] rem_hi;
	logic [cbe_pkg::REM_W-1:0] rem_lo;
	logic [cbe_pkg::CW_W-1:0] cw_hi;
	logic [cbe_pkg::CW_W-1:0] cw_lo;
	logic [cbe_pkg::NB_W-1:0] nb8;
	logic [cbe_pkg::NB_W-1:0] nb4;

	// clamp generator length, degree is one less
	always_comb begin
		if (cfg.gen_len < 5'd2) begin
			eff_len = 5'd2;
		end else if (cfg.gen_len > 5'(cbe_pkg::MAX_GEN_BITS)) begin
			eff_len = 5'(cbe_pkg::MAX_GEN_BITS);
		end else begin
			eff_len = cfg.gen_len;
		end
		g = 4'(eff_len - 5'd1);
	end

	// generator without its leading one, left aligned to the top bit
	always_comb begin
		mask = 16'((17'd1 << g) - 17'd1);
		poly_l = (cfg.gen_bits & mask) << (5'd16 - {1'b0, g});
	end

	// msb-first lfsr over the byte and over each nibble
	always_comb begin
		logic fb;
		rem8 = '0;
		rem_hi = '0;
		rem_lo = '0;
		for (int i = 0; i < cbe_pkg::BYTE_W; i++) begin
			fb = rem8[cbe_pkg::REM_W-1] ^ data_byte[cbe_pkg::BYTE_W-1-i];
			rem8 = {rem8[cbe_pkg::REM_W-2:0], 1'b0} ^ (fb ? poly_l : '0);
		end
		for (int i = 0; i < cbe_pkg::NIB_W; i++) begin
			fb = rem_hi[cbe_pkg::REM_W-1] ^ data_byte[cbe_pkg::BYTE_W-1-i];
			rem_hi = {rem_hi[cbe_pkg::REM_W-2:0], 1'b0} ^ (fb ? poly_l : '0);
			fb = rem_lo[cbe_pkg::REM_W-1] ^ data_byte[cbe_pkg::NIB_W-1-i];
			rem_lo = {rem_lo[cbe_pkg::REM_W-2:0], 1'b0} ^ (fb ? poly_l : '0);
		end
	end

	// codeword byte counts
	always_comb begin
		nb8 = (g <= 4'd8) ? 2'd2 : 2'd3;
		if (g <= 4'd4) begin
			nb4 = 2'd1;
		end else if (g <= 4'd12) begin
			nb4 = 2'd2;
		end else begin
			nb4 = 2'd3;
		end
	end

	// left aligned nibble codewords, zero padded
	assign cw_hi = {data_byte[7:4], rem_hi, 4'b0};
	assign cw_lo = {data_byte[3:0], rem_lo, 4'b0};

	// pack codewords back to back, first byte on top
	always_comb begin
		if (cfg.nibble_mode) begin
			case (nb4)
				2'd1: frame.bytes = {cw_hi[23:16], cw_lo, 16'b0};
				2'd2: frame.bytes = {cw_hi[23:8], cw_lo, 8'b0};
				default: frame.bytes = {cw_hi, cw_lo};
			endcase
			frame.count = {nb4, 1'b0};
		end else begin
			frame.bytes = {data_byte, rem8, 24'b0};
			frame.count = {1'b0, nb8};
		end
	end

endmodule
`default_nettype wire

// ===== design/cbe_serial.sv =====
// output byte shifter, one codeword byte per cycle while m_tready is high
`default_nettype none
module cbe_serial (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire cbe_pkg::frame_t              frame,
	input  wire logic                         frame_valid,
	output logic                              take,
	output logic                              m_tvalid,
	input  wire logic                         m_tready,
	output logic [cbe_pkg::BYTE_W-1:0]        m_tdata,
	output logic                              m_tlast
);

	logic [cbe_pkg::STREAM_W-1:0] bytes_q;
	logic [cbe_pkg::CNT_W-1:0] cnt_q;
	logic pop;

	// load a new frame when empty or when the last byte leaves
	assign m_tvalid = (cnt_q != '0);
	assign m_tlast = (cnt_q == 3'd1);
	assign pop = m_tvalid && m_tready;
	assign take = frame_valid && (!m_tvalid || (pop && m_tlast));
	assign m_tdata = bytes_q[cbe_pkg::STREAM_W-1 -: cbe_pkg::BYTE_W];

	// remaining byte count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (take) begin
			cnt_q <= frame.count;
		end else if (pop) begin
			cnt_q <= cnt_q - 3'd1;
		end
	end

	// byte shifter
	always_ff @(posedge clk) begin
		if (take) begin
			bytes_q <= frame.bytes;
		end else if (pop) begin
			bytes_q <= {bytes_q[cbe_pkg::STREAM_W-cbe_pkg::BYTE_W-1:0], 8'b0};
		end
	end

`ifndef SYNTH
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 3'(cbe_pkg::MAX_BYTES))
		else $error("byte count above maximum");
	a_pop_dec: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !m_tlast) |=> (cnt_q == $past(cnt_q) - 3'd1))
		else $error("byte count did not step down");
	a_load_count: assert property (@(posedge clk) disable iff (!arst_n)
		take |-> (frame.count >= 3'd2 && frame.count <= 3'(cbe_pkg::MAX_BYTES)))
		else $error("frame byte count out of range");
	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tlast) |-> !take)
		else $error("frame loaded over pending bytes");
`endif

endmodule
`default_nettype wire

// ===== design/crc_codeword_byte_encoder_unit.sv =====
// top level of the crc codeword byte encoder
//
// channel  dir  signals                       payload
// s        in   s_tvalid s_tready s_tdata     data_byte
// m        out  m_tvalid m_tready m_tdata     out_byte, m_tlast = last
// cfg      in   cfg_we cfg_index cfg_data     gen_len, gen_bits, nibble_mode
//
// each item gives 2 to 6 output bytes, one per cycle while m_tready is high:
// 2 or 3 in 8-bit mode, the sum of both nibble codewords in 4-bit mode; the
// output shifter sets the rate. items pass the input register, then the shifter.
// the input register takes a new item while the shifter still drains.
// reset clears valid flags and loads the default configuration.
`default_nettype none
module crc_codeword_byte_encoder_unit (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        s_tvalid,
	output logic                             s_tready,
	input  wire logic [cbe_pkg::BYTE_W-1:0]  s_tdata,   // [7:0] data_byte
	output logic                             m_tvalid,
	input  wire logic                        m_tready,
	output logic [cbe_pkg::BYTE_W-1:0]       m_tdata,   // [7:0] out_byte
	output logic                             m_tlast,
	input  wire logic                        cfg_we,
	input  wire logic [1:0]                  cfg_index,
	input  wire logic [cbe_pkg::REM_W-1:0]   cfg_data
);

	cbe_pkg::cfg_t cfg_q;
	cbe_pkg::frame_t frame;
	logic [cbe_pkg::BYTE_W-1:0] byte_s1;
	logic valid_s1;
	logic take;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gen_len <= 5'd4;
			cfg_q.gen_bits <= 16'd13;
			cfg_q.nibble_mode <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				cbe_pkg::REG_GEN_LEN: cfg_q.gen_len <= cfg_data[cbe_pkg::LEN_W-1:0];
				cbe_pkg::REG_GEN_BITS: cfg_q.gen_bits <= cfg_data;
				cbe_pkg::REG_NIBBLE_MODE: cfg_q.nibble_mode <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// input register
	assign s_tready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (take) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
		end
	end

	// remainder and packing
	cbe_core u_core (
		.cfg       (cfg_q),
		.data_byte (byte_s1),
		.frame     (frame)
	);

	// output shifter
	cbe_serial u_serial (
		.clk         (clk),
		.arst_n      (arst_n),
		.frame       (frame),
		.frame_valid (valid_s1),
		.take        (take),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tlast     (m_tlast)
	);

endmodule
`default_nettype wire

// ===== tb/cbe_checker.sv =====
// checker for the crc codeword byte encoder: tracks config, predicts output bytes, compares
`timescale 1ns / 1ps
`default_nettype none
module cbe_checker (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        s_tvalid,
	input  wire logic                        s_tready,
	input  wire logic [cbe_pkg::BYTE_W-1:0]  s_tdata,   // [7:0] data_byte
	input  wire logic                        m_tvalid,
	input  wire logic                        m_tready,
	input  wire logic [cbe_pkg::BYTE_W-1:0]  m_tdata,   // [7:0] out_byte
	input  wire logic                        m_tlast,
	input  wire logic                        cfg_we,
	input  wire logic [1:0]                  cfg_index,
	input  wire logic [cbe_pkg::REM_W-1:0]   cfg_data,
	output int                               errors,
	output int                               pending
);

	typedef struct packed {
		logic [cbe_pkg::BYTE_W-1:0] out_byte;
		logic last;
	} cw_byte_t;

	// shadow copy of the configuration registers
	logic [cbe_pkg::LEN_W-1:0] poly_len = 5'd4;
	logic [cbe_pkg::REM_W-1:0] poly_bits = 16'd13;
	logic nibble_sel = 1'b0;

	cw_byte_t codeword_q[$];
	int fail_count = 0;

	assign errors = fail_count;

	// remainder of the dataword shifted left by g, modulo the generator of degree g
	function automatic logic [31:0] crc_remainder(input logic [7:0] dw, input int unsigned w,
			input int unsigned g);
		logic [31:0] mask;
		logic [31:0] poly;
		logic [31:0] r;
		mask = (32'd1 << g) - 32'd1;
		poly = ({16'h0, poly_bits} & mask) | (32'd1 << g);
		r = '0;
		for (int i = 0; i < w + g; i++) begin
			r = r << 1;
			if (i < w)
				r[0] = dw[w - 1 - i];
			if (r[g])
				r = r ^ poly;
		end
		return r & mask;
	endfunction

	// queue the zero-padded codeword bytes of one dataword, most significant first
	function automatic void queue_codeword(input logic [7:0] dw, input int unsigned w,
			input int unsigned g);
		logic [31:0] cw;
		int unsigned cw_len;
		int unsigned nb;
		cw = ({24'h0, dw} << g) | crc_remainder(dw, w, g);
		cw_len = w + g;
		nb = (cw_len + 7) / 8;
		cw = cw << (nb * 8 - cw_len);
		for (int j = 0; j < nb; j++)
			codeword_q.push_back('{out_byte: cw[8 * (nb - 1 - j) +: 8], last: 1'b0});
	endfunction

	// expected bytes for one accepted data byte
	function automatic void predict_item(input logic [7:0] d);
		int unsigned eff;
		eff = 32'(poly_len);
		if (eff < 2)
			eff = 2;
		if (eff > cbe_pkg::MAX_GEN_BITS)
			eff = cbe_pkg::MAX_GEN_BITS;
		if (nibble_sel) begin
			queue_codeword({4'h0, d[7:4]}, cbe_pkg::NIB_W, eff - 1);
			queue_codeword({4'h0, d[3:0]}, cbe_pkg::NIB_W, eff - 1);
		end else begin
			queue_codeword(d, cbe_pkg::BYTE_W, eff - 1);
		end
		codeword_q[codeword_q.size() - 1].last = 1'b1;
	endfunction

	// watch all three channels
	always @(posedge clk or negedge arst_n) begin
		cw_byte_t exp_byte;
		if (!arst_n) begin
			poly_len = 5'd4;
			poly_bits = 16'd13;
			nibble_sel = 1'b0;
			codeword_q.delete();
		end else begin
			// output side first: a result never shares its edge with its own item
			if (m_tvalid && m_tready) begin
				if (codeword_q.size() == 0) begin
					$error("unexpected item: out_byte %02h last %0b", m_tdata, m_tlast);
					fail_count++;
				end else begin
					exp_byte = codeword_q.pop_front();
					if (m_tdata !== exp_byte.out_byte) begin
						$error("out_byte: expected %02h, actual %02h", exp_byte.out_byte, m_tdata);
						fail_count++;
					end
					if (m_tlast !== exp_byte.last) begin
						$error("last: expected %0b, actual %0b", exp_byte.last, m_tlast);
						fail_count++;
					end
				end
			end
			if (s_tvalid && s_tready)
				predict_item(s_tdata);
			if (cfg_we) begin
				case (cfg_index)
					cbe_pkg::REG_GEN_LEN: poly_len = cfg_data[cbe_pkg::LEN_W-1:0];
					cbe_pkg::REG_GEN_BITS: poly_bits = cfg_data;
					cbe_pkg::REG_NIBBLE_MODE: nibble_sel = cfg_data[0];
					default: ;
				endcase
			end
		end
		pending = codeword_q.size();
	end

endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
// testbench top for the crc codeword byte encoder: stimulus, flow control and verdict
`timescale 1ns / 1ps
`default_nettype none
module tb_top;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [cbe_pkg::BYTE_W-1:0] s_tdata = '0;   // [7:0] data_byte
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [cbe_pkg::BYTE_W-1:0] m_tdata;        // [7:0] out_byte
	logic m_tlast;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = cbe_pkg::REG_GEN_LEN;
	logic [cbe_pkg::REM_W-1:0] cfg_data = '0;

	int errors;
	int pending;
	int send_idle = 14;
	int recv_idle = 78;

	always #2 clk = ~clk;

	crc_codeword_byte_encoder_unit i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	cbe_checker i_checker (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.errors(errors),
		.pending(pending)
	);

	// receiver back-pressure
	always @(negedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_idle);
	end

	// offer one data byte, with random gaps, until it is taken
	task automatic send_byte(input logic [7:0] d);
		@(negedge clk);
		while ($urandom_range(99) < send_idle) begin
			s_tvalid <= 1'b0;
			s_tdata <= 8'($urandom);
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= d;
		do @(posedge clk); while (!s_tready);
	endtask

	// stop sending and let every expected byte come out
	task automatic drain;
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	// write all three registers back to back
	task automatic set_config(input logic [4:0] len, input logic [15:0] bits, input logic nib);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= cbe_pkg::REG_GEN_LEN;
		cfg_data <= {11'h0, len};
		@(negedge clk);
		cfg_index <= cbe_pkg::REG_GEN_BITS;
		cfg_data <= bits;
		@(negedge clk);
		cfg_index <= cbe_pkg::REG_NIBBLE_MODE;
		cfg_data <= {15'h0, nib};
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// fail safe
	initial begin
		#1600000;
		$display("tb_top NOT OK");
		$finish;
	end

	initial begin
		logic [4:0] len;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;

		// reset configuration, byte extremes
		send_byte(8'h00);
		send_byte(8'hff);
		send_byte(8'h80);
		send_byte(8'h01);
		send_byte(8'ha5);
		drain();

		// widest generator, three bytes per item
		set_config(5'd16, 16'hffff, 1'b0);
		send_byte(8'h00);
		send_byte(8'hff);
		send_byte(8'h81);
		drain();

		// shortest generator in nibble mode, one byte per nibble
		set_config(5'd2, 16'h0000, 1'b1);
		send_byte(8'h00);
		send_byte(8'hff);
		send_byte(8'hf0);
		send_byte(8'h0f);
		drain();

		// widest generator in nibble mode, six bytes per item
		set_config(5'd16, 16'h8005, 1'b1);
		send_byte(8'hff);
		send_byte(8'h3c);
		drain();

		// length below range clamps to two
		set_config(5'd0, 16'hffff, 1'b0);
		send_byte(8'hc3);
		send_byte(8'h7e);
		drain();
		set_config(5'd1, 16'h5555, 1'b1);
		send_byte(8'h96);
		drain();

		// length above range clamps to the maximum
		set_config(5'd31, 16'h1021, 1'b0);
		send_byte(8'h5a);
		drain();
		set_config(5'd17, 16'h0000, 1'b1);
		send_byte(8'he7);
		drain();

		// leading generator bit clear and junk above it
		set_config(5'd9, 16'hfe07, 1'b0);
		send_byte(8'hb4);
		send_byte(8'h4b);
		drain();

		// random configurations and data under three flow control regimes
		for (int ph = 0; ph < 23; ph++) begin
			if (ph < 8) begin
				send_idle = 14;
				recv_idle = 78;
			end else if (ph < 16) begin
				send_idle = 78;
				recv_idle = 14;
			end else begin
				send_idle = 0;
				recv_idle = 0;
			end
			if ($urandom_range(99) < 75)
				len = 5'($urandom_range(2, 16));
			else
				len = 5'($urandom_range(0, 31));
			set_config(len, 16'($urandom), 1'($urandom_range(1)));
			for (int n = 0; n < 20; n++)
				send_byte(8'($urandom));
			drain();
		end

		repeat (20) @(negedge clk);
		if (errors == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

endmodule
`default_nettype wire
